[design/sep_pkg.sv]
// Package for the scanning eye position unit: widths, reset values and register indexes.
// Also holds the divide-by-255 helper used when scaling the eye color.
// No dependencies.
package sep_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned POS_OUT_W = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PROD_W    = 2 * DATA_W;

    // Default strip length.
    localparam int unsigned NUM_LEDS_DEF = 64;

    // Eye advance per move.
    localparam int unsigned EYE_STEP = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_PERIOD = 3'd0,
        REG_INTENSITY   = 3'd1,
        REG_RED         = 3'd2,
        REG_GREEN       = 3'd3,
        REG_BLUE        = 3'd4
    } t_cfg_reg;

    // Register reset values.
    localparam logic [DATA_W-1:0] STEP_PERIOD_RST = 8'd10;
    localparam logic [DATA_W-1:0] INTENSITY_RST   = 8'd255;
    localparam logic [DATA_W-1:0] RED_RST         = 8'd255;
    localparam logic [DATA_W-1:0] GREEN_RST       = 8'd0;
    localparam logic [DATA_W-1:0] BLUE_RST        = 8'd0;

    // Exact floor(x / 255) for any x up to 255 * 255: (x + (x >> 8) + 1) >> 8.
    function automatic logic [DATA_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] sum;
        sum = {1'b0, x} + {{(DATA_W + 1){1'b0}}, x[PROD_W-1:DATA_W]} + {{PROD_W{1'b0}}, 1'b1};
        return sum[PROD_W-1:DATA_W];
    endfunction

endpackage

[design/scanning_eye_position_unit.sv]
// Scanning eye position unit: a bouncing single-LED scanner with an intensity-scaled color.
// Depends on sep_pkg for widths, register indexes, reset values and the divide-by-255 helper.
//
// Each accepted transaction on the input channel is one display tick and produces exactly one
// result transaction. The block takes a new transaction every clock cycle while the output is
// not stalled: at the accepting edge the eye state is updated and the new eye, together with the
// three 8x8 color products divided by 255, is loaded into the output register, so a result is
// offered in the cycle after its tick is accepted. The input is held off only while a result
// waits in the output register and the receiver is not ready. When the tick bit is low the state
// holds and the current eye is still reported. Configuration writes are always accepted and take
// effect at once; they should be made while the block is idle.
module scanning_eye_position_unit #(
    parameter int unsigned NUM_LEDS_P = sep_pkg::NUM_LEDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Tick channel.
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_tick,
    // Result channel.
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [sep_pkg::POS_OUT_W-1:0] o_eye_position,
    output logic [sep_pkg::DATA_W-1:0]    o_eye_red,
    output logic [sep_pkg::DATA_W-1:0]    o_eye_green,
    output logic [sep_pkg::DATA_W-1:0]    o_eye_blue,
    output logic                         o_moving_up,
    // Configuration write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sep_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sep_pkg::DATA_W-1:0]    i_cfg_data
);
    import sep_pkg::*;

    localparam int unsigned POS_W = $clog2(NUM_LEDS_P);
    localparam int unsigned NXT_W = POS_W + 1;
    localparam logic [POS_W-1:0] POS_TOP = POS_W'(NUM_LEDS_P - 1);
    localparam logic [NXT_W-1:0] POS_LIMIT = NXT_W'(NUM_LEDS_P);
    localparam logic [POS_W-1:0] STEP_POS = POS_W'(EYE_STEP);

    // Configuration registers.
    logic [DATA_W-1:0] r_step_period;
    logic [DATA_W-1:0] r_intensity;
    logic [DATA_W-1:0] r_red;
    logic [DATA_W-1:0] r_green;
    logic [DATA_W-1:0] r_blue;

    // Eye state.
    logic [POS_W-1:0]  r_position, n_position;
    logic [DATA_W-1:0] r_step_count, n_step_count;
    logic [DATA_W-1:0] r_dwell_count, n_dwell_count;
    logic              r_going_up, n_going_up;

    // Output register.
    logic                 r_out_valid;
    logic [POS_W-1:0]     r_out_position;
    logic [DATA_W-1:0]    r_out_red;
    logic [DATA_W-1:0]    r_out_green;
    logic [DATA_W-1:0]    r_out_blue;
    logic                 r_out_going_up;

    logic in_accept;
    logic out_advance;
    logic [NXT_W-1:0] pos_next_up;
    logic [POS_W+POS_OUT_W-1:0] pos_wide;
    logic [PROD_W-1:0] red_prod;
    logic [PROD_W-1:0] green_prod;
    logic [PROD_W-1:0] blue_prod;

    // Flow control: a tick is taken whenever the output register is free or being read.
    assign out_advance = !r_out_valid || i_ready;
    assign o_ready     = out_advance;
    assign in_accept   = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_period <= STEP_PERIOD_RST;
            r_intensity   <= INTENSITY_RST;
            r_red         <= RED_RST;
            r_green       <= GREEN_RST;
            r_blue        <= BLUE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_STEP_PERIOD: r_step_period <= i_cfg_data;
                REG_INTENSITY:   r_intensity   <= i_cfg_data;
                REG_RED:         r_red         <= i_cfg_data;
                REG_GREEN:       r_green       <= i_cfg_data;
                REG_BLUE:        r_blue        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next eye state for one tick: move when both counters are empty, else drain dwell, then step.
    assign pos_next_up = {1'b0, r_position} + NXT_W'(EYE_STEP);

    always_comb begin
        n_position    = r_position;
        n_step_count  = r_step_count;
        n_dwell_count = r_dwell_count;
        n_going_up    = r_going_up;
        if (i_tick) begin
            if (r_step_count == '0 && r_dwell_count == '0) begin
                n_step_count = r_step_period;
                if (r_going_up) begin
                    if (pos_next_up >= POS_LIMIT) begin
                        n_going_up    = 1'b0;
                        n_position    = POS_TOP;
                        n_dwell_count = r_intensity;
                    end else begin
                        n_position = pos_next_up[POS_W-1:0];
                    end
                end else if (r_position == '0) begin
                    n_going_up    = 1'b1;
                    n_dwell_count = r_intensity;
                end else if (r_position >= STEP_POS) begin
                    n_position = r_position - STEP_POS;
                end else begin
                    n_position = '0;
                end
            end else if (r_dwell_count != '0) begin
                n_dwell_count = r_dwell_count - DATA_W'(1);
            end else begin
                n_step_count = r_step_count - DATA_W'(1);
            end
        end
    end

    // Eye state registers, updated at each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position    <= '0;
            r_step_count  <= '0;
            r_dwell_count <= '0;
            r_going_up    <= 1'b1;
        end else if (in_accept) begin
            r_position    <= n_position;
            r_step_count  <= n_step_count;
            r_dwell_count <= n_dwell_count;
            r_going_up    <= n_going_up;
        end
    end

    // Raw color products from the present registers.
    assign red_prod   = PROD_W'(r_red) * PROD_W'(r_intensity);
    assign green_prod = PROD_W'(r_green) * PROD_W'(r_intensity);
    assign blue_prod  = PROD_W'(r_blue) * PROD_W'(r_intensity);

    // Output register: the updated eye and the colors divided by 255.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_position <= n_position;
            r_out_going_up <= n_going_up;
            r_out_red      <= div255(red_prod);
            r_out_green    <= div255(green_prod);
            r_out_blue     <= div255(blue_prod);
        end
    end

    // The reported position carries the low bits of the eye index.
    assign pos_wide       = {{POS_OUT_W{1'b0}}, r_out_position};
    assign o_valid        = r_out_valid;
    assign o_eye_position = pos_wide[POS_OUT_W-1:0];
    assign o_eye_red      = r_out_red;
    assign o_eye_green    = r_out_green;
    assign o_eye_blue     = r_out_blue;
    assign o_moving_up    = r_out_going_up;

    // The eye never leaves the strip.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= POS_TOP)
        else $error("eye position beyond the top of the strip");

    // While the dwell counter runs, a tick does not move the eye.
    a_dwell_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && r_dwell_count != '0 |=> $stable(r_position))
        else $error("eye moved during dwell");

    // Direction only turns around at one of the two ends.
    a_turn_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_going_up) |-> (r_position == '0 || r_position == POS_TOP))
        else $error("eye reversed away from an end");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the scanning eye position unit (bouncing single-LED scanner).
// Depends on sep_pkg for widths and register indexes and on the scanning_eye_position_unit RTL.
// Tick transactions are predicted as they are accepted; each result is compared field by field.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sep_pkg::*;

    localparam int unsigned NUM_LEDS       = NUM_LEDS_DEF;
    localparam int unsigned SCALE_DIV      = 255;
    localparam int unsigned HOLD_CYCLES    = 120;
    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_PHASES  = 13;
    localparam int unsigned PHASE_TICKS    = 42;

    // Expected contents of one result transaction.
    typedef struct packed {
        logic [POS_OUT_W-1:0] pos;
        logic [DATA_W-1:0]    red;
        logic [DATA_W-1:0]    green;
        logic [DATA_W-1:0]    blue;
        logic                 up;
    } t_eye_result;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic                 i_tick      = 1'b0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [POS_OUT_W-1:0] o_eye_position;
    logic [DATA_W-1:0]    o_eye_red;
    logic [DATA_W-1:0]    o_eye_green;
    logic [DATA_W-1:0]    o_eye_blue;
    logic                 o_moving_up;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_data  = '0;

    // Shadow copy of the configuration registers.
    logic [DATA_W-1:0] cfg_period    = STEP_PERIOD_RST;
    logic [DATA_W-1:0] cfg_intensity = INTENSITY_RST;
    logic [DATA_W-1:0] cfg_red       = RED_RST;
    logic [DATA_W-1:0] cfg_green     = GREEN_RST;
    logic [DATA_W-1:0] cfg_blue      = BLUE_RST;

    // Shadow copy of the scanner state.
    logic [7:0] eye_pos   = '0;
    logic [7:0] step_cnt  = '0;
    logic [7:0] dwell_cnt = '0;
    logic       going_up  = 1'b1;

    t_eye_result eye_expect_q[$];
    int          mismatches   = 0;
    int unsigned idle_cycles  = 0;

    // Sender and receiver idling controls; the limits are set between phases.
    int unsigned gap_max      = 0;
    int unsigned burst_max    = 1;
    int unsigned burst_left   = 0;
    int unsigned stall_pct    = 0;
    int unsigned tick_low_pct = 15;
    int unsigned hold_reqs    = 0;
    int unsigned hold_acks    = 0;
    int unsigned hold_left    = 0;

    scanning_eye_position_unit #(
        .NUM_LEDS_P(NUM_LEDS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_tick         (i_tick),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_eye_position (o_eye_position),
        .o_eye_red      (o_eye_red),
        .o_eye_green    (o_eye_green),
        .o_eye_blue     (o_eye_blue),
        .o_moving_up    (o_moving_up),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Color level scaled by the present intensity, truncated.
    function automatic logic [DATA_W-1:0] scale_by_intensity(input logic [DATA_W-1:0] level);
        int unsigned prod;
        prod = int'(level) * int'(cfg_intensity);
        return DATA_W'(prod / SCALE_DIV);
    endfunction

    // Advances the shadow scanner by one tick and returns the result it reports.
    function automatic t_eye_result next_eye_result(input logic tick_bit);
        t_eye_result res;
        int unsigned next_pos;
        if (tick_bit) begin
            if (step_cnt == 0 && dwell_cnt == 0) begin
                step_cnt = cfg_period;
                if (going_up) begin
                    next_pos = int'(eye_pos) + EYE_STEP;
                    if (next_pos >= NUM_LEDS) begin
                        going_up  = 1'b0;
                        eye_pos   = 8'(NUM_LEDS - 1);
                        dwell_cnt = cfg_intensity;
                    end else begin
                        eye_pos = 8'(next_pos);
                    end
                end else if (eye_pos == 0) begin
                    going_up  = 1'b1;
                    dwell_cnt = cfg_intensity;
                end else begin
                    eye_pos = (eye_pos >= EYE_STEP) ? 8'(eye_pos - EYE_STEP) : 8'd0;
                end
            end else if (dwell_cnt != 0) begin
                dwell_cnt = dwell_cnt - 8'd1;
            end else begin
                step_cnt = step_cnt - 8'd1;
            end
        end
        res.pos   = eye_pos[POS_OUT_W-1:0];
        res.red   = scale_by_intensity(cfg_red);
        res.green = scale_by_intensity(cfg_green);
        res.blue  = scale_by_intensity(cfg_blue);
        res.up    = going_up;
        return res;
    endfunction

    // Writes one register and waits for the transaction; valid stays high for the caller.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_STEP_PERIOD: cfg_period    = data;
            REG_INTENSITY:   cfg_intensity = data;
            REG_RED:         cfg_red       = data;
            REG_GREEN:       cfg_green     = data;
            REG_BLUE:        cfg_blue      = data;
            default: ;
        endcase
    endtask

    // Writes all five registers, sometimes followed by a write to an unused index.
    task automatic set_config(input logic [DATA_W-1:0] period, input logic [DATA_W-1:0] inten,
                              input logic [DATA_W-1:0] r, input logic [DATA_W-1:0] g,
                              input logic [DATA_W-1:0] b);
        cfg_write(REG_STEP_PERIOD, period);
        cfg_write(REG_INTENSITY, inten);
        cfg_write(REG_RED, r);
        cfg_write(REG_GREEN, g);
        cfg_write(REG_BLUE, b);
        if ($urandom_range(0, 2) == 0) begin
            cfg_write(CFG_IDX_W'($urandom_range(int'(REG_BLUE) + 1, (1 << CFG_IDX_W) - 1)),
                      DATA_W'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Sends one tick transaction, opening a random gap when a burst runs out.
    task automatic send_tick(input logic tick_bit);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_tick  <= tick_bit;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        eye_expect_q.push_back(next_eye_result(tick_bit));
    endtask

    // Ends a stream and waits until every expected result has been seen.
    task automatic drain_phase();
        i_valid <= 1'b0;
        while (eye_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register values straight after reset, with the tick low and high.
    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b1);
        drain_phase();
    endtask

    // Fastest step period while the eye scans up the strip, with one tick low on the way.
    task automatic test_top_overshoot();
        set_config(8'd0, 8'd1, 8'd255, 8'd128, 8'd1);
        for (int i = 0; i < 23; i++) send_tick(i != 20);
        drain_phase();
    endtask

    // The receiver holds off for a long stretch while ticks keep coming, so the block fills up.
    task automatic test_backpressure();
        gap_max   = 0;
        burst_max = 1;
        stall_pct = 0;
        set_config(8'd1, 8'd2, 8'd255, 8'd255, 8'd255);
        hold_reqs <= hold_reqs + 1;
        for (int i = 0; i < 45; i++) send_tick($urandom_range(0, 99) >= tick_low_pct);
        drain_phase();
    endtask

    // One phase of random ticks under a random setting and random idling.
    task automatic test_random_phase(input int unsigned n_ticks);
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] inten;
        logic [DATA_W-1:0] rgb[3];
        case ($urandom_range(0, 7))
            0:       period = 8'd0;
            1:       period = 8'd1;
            2:       period = 8'd2;
            3:       period = 8'd255;
            4:       period = DATA_W'($urandom);
            default: period = DATA_W'($urandom_range(0, 6));
        endcase
        case ($urandom_range(0, 6))
            0:       inten = 8'd0;
            1:       inten = 8'd255;
            2:       inten = DATA_W'($urandom);
            default: inten = DATA_W'($urandom_range(1, 8));
        endcase
        foreach (rgb[k]) begin
            case ($urandom_range(0, 3))
                0:       rgb[k] = 8'd0;
                1:       rgb[k] = 8'd255;
                default: rgb[k] = DATA_W'($urandom);
            endcase
        end
        set_config(period, inten, rgb[0], rgb[1], rgb[2]);
        gap_max      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_max    = $urandom_range(1, 20);
        burst_left   = 0;
        stall_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
        tick_low_pct = $urandom_range(0, 30);
        for (int i = 0; i < n_ticks; i++) send_tick($urandom_range(0, 99) >= tick_low_pct);
        drain_phase();
    endtask

    // Reports one field mismatch.
    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Receiver: a random stall pattern, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_reqs != hold_acks) begin
            hold_acks <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compares each result transaction with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_eye_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (eye_expect_q.size() == 0) begin
                $error("result transaction with no tick pending");
                mismatches++;
            end else begin
                exp_res = eye_expect_q.pop_front();
                check_field("eye_position", exp_res.pos, o_eye_position);
                check_field("eye_red", exp_res.red, o_eye_red);
                check_field("eye_green", exp_res.green, o_eye_green);
                check_field("eye_blue", exp_res.blue, o_eye_blue);
                check_field("moving_up", exp_res.up, o_moving_up);
            end
        end
    end

    // Watchdog: ends the run when no transaction has completed for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_top_overshoot();
        test_backpressure();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) test_random_phase(PHASE_TICKS);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
